### hdl/fpgt_pkg.sv
// Shared types, constants and rule tables of the fuzzy PID gain tuner.
// Used by the front end, the queue, the back end and the top level.
package fpgt_pkg;

	// Fixed-point format of the fuzzy universe and input error width
	localparam int FRAC_BITS   = 12;
	localparam int ERROR_WIDTH = 16;

	// Register widths
	localparam int SCALE_W = 32;
	localparam int GAIN_W  = 16;
	localparam int CFG_W   = 32;
	localparam int OUT_W   = 18;

	// Stream data widths (zero-padded to whole bytes)
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;

	// Derived widths of the datapath
	localparam int DIFF_W  = ERROR_WIDTH + 1;          // error change, signed
	localparam int PROD_W  = DIFF_W + SCALE_W;         // |x| * quant_scale
	localparam int QM_W    = PROD_W - 16;              // Q16.16 product shifted down
	localparam int MEM_W   = FRAC_BITS + 1;            // membership, 0..1.0
	localparam int U_W     = FRAC_BITS + 3;            // universe shifted to 0..6
	localparam int SEG_W   = 3;
	localparam int RULE_W  = 3;
	localparam int INNER_W = FRAC_BITS + 3;            // c0*t0 + c1*t1
	localparam int SUM_W   = 2 * FRAC_BITS + 3;        // weighted corner sum
	localparam int PG_W    = SUM_W + GAIN_W;           // sum times gain
	localparam int RES_LSB = 2 * FRAC_BITS;

	localparam int ONE = 1 << FRAC_BITS;
	localparam int TOP = 3 * ONE;
	localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(5);

	// Decoupling queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_QUANT_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 2'd3;

	localparam logic [SCALE_W-1:0]       QUANT_SCALE_RST = 32'd65536;
	localparam logic signed [GAIN_W-1:0] GAIN_RST        = 16'sd256;

	// Output lanes
	localparam int LANES = 3;
	localparam logic [1:0] LANE_P = 2'd0;
	localparam logic [1:0] LANE_I = 2'd1;
	localparam logic [1:0] LANE_D = 2'd2;

	// Fuzzified item passed from front to back
	typedef struct packed {
		logic             ok;       // both values inside [-3,3]
		logic [SEG_W-1:0] seg_e;
		logic [SEG_W-1:0] seg_c;
		logic [MEM_W-1:0] e0;
		logic [MEM_W-1:0] e1;
		logic [MEM_W-1:0] c0;
		logic [MEM_W-1:0] c1;
	} fuzz_t;

	// Rule bases, row = error set, column = change set
	localparam logic signed [RULE_W-1:0] RULE_P [7][7] = '{
		'{ 3,  3,  2,  2,  1,  0,  0},
		'{ 3,  3,  2,  1,  1,  0, -1},
		'{ 2,  2,  2,  1,  0, -1, -1},
		'{ 2,  1,  1,  0, -1, -2, -2},
		'{ 1,  1,  0, -1, -1, -2, -2},
		'{ 1,  0, -1, -2, -2, -2, -3},
		'{ 0,  0, -2, -2, -2, -3, -3}
	};

	localparam logic signed [RULE_W-1:0] RULE_I [7][7] = '{
		'{-3, -3, -2, -2, -1,  0,  0},
		'{-3, -3, -2, -1, -1,  0,  0},
		'{-3, -2, -1, -1,  0,  1,  1},
		'{-2, -1, -1,  0,  1,  2,  2},
		'{-1, -1,  0,  1,  1,  2,  3},
		'{ 0,  0,  1,  1,  2,  3,  3},
		'{ 0,  0,  1,  2,  2,  3,  3}
	};

	localparam logic signed [RULE_W-1:0] RULE_D [7][7] = '{
		'{ 1, -1, -3, -3, -3, -2,  1},
		'{ 1, -1, -3, -2, -2, -1,  0},
		'{ 0, -1, -2, -2, -1, -1,  0},
		'{ 0, -1, -1, -1, -1, -1,  0},
		'{ 0,  0,  0,  0,  0,  0,  0},
		'{ 3, -1,  1,  1,  1,  1,  3},
		'{ 3,  2,  2,  2,  1,  1,  3}
	};

	// Rule entry of one lane
	function automatic logic signed [RULE_W-1:0] rule_at(input logic [1:0] lane,
			input logic [SEG_W-1:0] row, input logic [SEG_W-1:0] col);
		logic signed [RULE_W-1:0] v;
		case (lane)
			LANE_P:  v = RULE_P[row][col];
			LANE_I:  v = RULE_I[row][col];
			default: v = RULE_D[row][col];
		endcase
		return v;
	endfunction

endpackage

### hdl/fpgt_front.sv
// Front end: accepts error items, scales error and change into the fuzzy
// universe and finds segments and memberships. Depends on fpgt_pkg.
module fpgt_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [fpgt_pkg::ERROR_WIDTH-1:0] error_now,
	input  logic signed [fpgt_pkg::ERROR_WIDTH-1:0] error_prev,
	input  logic [fpgt_pkg::SCALE_W-1:0]   quant_scale,
	output logic                           push,
	input  logic                           q_ready,
	output fpgt_pkg::fuzz_t                push_data
);
	import fpgt_pkg::*;

	typedef struct packed {
		logic             ok;
		logic [SEG_W-1:0] seg;
		logic [MEM_W-1:0] m0;
		logic [MEM_W-1:0] m1;
	} memb_t;

	// Q16.16 product to segment and triangular memberships
	function automatic memb_t fuzzify(input logic [PROD_W-1:0] prod, input logic neg);
		logic [QM_W-1:0]           qm;
		logic [U_W-1:0]            u;
		logic [U_W-FRAC_BITS-1:0]  k;
		memb_t                     r;
		// negative side rounds magnitude up so q is a floor
		qm   = prod[PROD_W-1:16] + QM_W'(neg && (prod[15:0] != '0));
		r.ok = (qm <= QM_W'(TOP));
		u    = neg ? U_W'(TOP) - qm[U_W-1:0] : U_W'(TOP) + qm[U_W-1:0];
		k    = u[U_W-1:FRAC_BITS];
		// exactly +3 stays on the last segment
		if (k > SEG_MAX) begin
			r.seg = SEG_MAX;
			r.m1  = MEM_W'(ONE);
		end else begin
			r.seg = k;
			r.m1  = {1'b0, u[FRAC_BITS-1:0]};
		end
		r.m0 = MEM_W'(ONE) - r.m1;
		return r;
	endfunction

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic              neg_e_s1, neg_c_s1;
	logic [DIFF_W-1:0] mag_e_s1, mag_c_s1;
	logic              neg_e_s2, neg_c_s2;
	logic [PROD_W-1:0] prod_e_s2, prod_c_s2;
	fuzz_t             fuzz_s3;

	logic signed [DIFF_W-1:0] now_x, prev_x, diff_x;
	memb_t me, mc;

	// whole front moves unless the last stage is blocked by a full queue
	assign adv      = !(v_s3 && !q_ready);
	assign in_ready = adv;
	assign push     = v_s3 && adv;
	assign push_data = fuzz_s3;

	assign now_x  = DIFF_W'(error_now);
	assign prev_x = DIFF_W'(error_prev);
	assign diff_x = now_x - prev_x;

	assign me = fuzzify(prod_e_s2, neg_e_s2);
	assign mc = fuzzify(prod_c_s2, neg_c_s2);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// s1 sign/magnitude, s2 scaling multiply, s3 fuzzification
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_e_s1  <= now_x[DIFF_W-1];
			mag_e_s1  <= now_x[DIFF_W-1] ? DIFF_W'(-now_x) : DIFF_W'(now_x);
			neg_c_s1  <= diff_x[DIFF_W-1];
			mag_c_s1  <= diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
			neg_e_s2  <= neg_e_s1;
			neg_c_s2  <= neg_c_s1;
			prod_e_s2 <= PROD_W'(mag_e_s1) * PROD_W'(quant_scale);
			prod_c_s2 <= PROD_W'(mag_c_s1) * PROD_W'(quant_scale);
			fuzz_s3.ok    <= me.ok && mc.ok;
			fuzz_s3.seg_e <= me.seg;
			fuzz_s3.seg_c <= mc.seg;
			fuzz_s3.e0    <= me.m0;
			fuzz_s3.e1    <= me.m1;
			fuzz_s3.c0    <= mc.m0;
			fuzz_s3.c1    <= mc.m1;
		end
	end

endmodule

### hdl/fpgt_queue.sv
// Short FIFO of fuzzified items between front end and back end.
// Depends on fpgt_pkg for the entry type and depth.
module fpgt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fpgt_pkg::fuzz_t push_data,
	output logic            q_ready,
	output logic            q_valid,
	input  logic            pop,
	output fpgt_pkg::fuzz_t pop_data
);
	import fpgt_pkg::*;

	fuzz_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign q_ready  = (count_q != (QPTR_W+1)'(QDEPTH));
	assign q_valid  = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

### hdl/fpgt_back.sv
// Back end: weights the four rule corners of each table by the memberships
// and scales by the gains, then holds the result item. Depends on fpgt_pkg.
module fpgt_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	output logic                                pop,
	input  fpgt_pkg::fuzz_t                     pop_data,
	input  logic signed [fpgt_pkg::GAIN_W-1:0]  gain [fpgt_pkg::LANES],
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fpgt_pkg::OUT_W-1:0]   result [fpgt_pkg::LANES]
);
	import fpgt_pkg::*;

	// membership times rule entry, both extended before the multiply
	function automatic logic signed [INNER_W-1:0] mul_rule(input logic [MEM_W-1:0] m,
			input logic signed [RULE_W-1:0] t);
		logic signed [INNER_W-1:0] ms, ts;
		ms = INNER_W'($signed({1'b0, m}));
		ts = INNER_W'(t);
		return ms * ts;
	endfunction

	logic be;
	logic v_s4, v_s5, v_s6;
	logic ok_s4, ok_s5, ok_s6;
	logic [MEM_W-1:0]          e0_s4, e1_s4;
	logic signed [INNER_W-1:0] a0_s4 [LANES];
	logic signed [INNER_W-1:0] a1_s4 [LANES];
	logic signed [SUM_W-1:0]   sum_s5 [LANES];
	logic signed [PG_W-1:0]    pg_s6 [LANES];
	logic signed [OUT_W-1:0]   res_q [LANES];
	logic                      out_valid_q;

	logic [SEG_W-1:0] row0, row1, col0, col1;

	assign be        = !out_valid_q || out_ready;
	assign pop       = q_valid && be;
	assign out_valid = out_valid_q;
	assign result    = res_q;

	assign row0 = pop_data.seg_e;
	assign row1 = pop_data.seg_e + 1'b1;
	assign col0 = pop_data.seg_c;
	assign col1 = pop_data.seg_c + 1'b1;

	// stage valids and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (be) begin
			v_s4        <= q_valid;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	// s4 change weighting, s5 error weighting, s6 gain, then floor shift
	// the sum is bounded by 3*2^(2F), so the shifted product always fits OUT_W
	always_ff @(posedge clk) begin
		if (be) begin
			ok_s4 <= pop_data.ok;
			e0_s4 <= pop_data.e0;
			e1_s4 <= pop_data.e1;
			ok_s5 <= ok_s4;
			ok_s6 <= ok_s5;
			for (int l = 0; l < LANES; l++) begin
				a0_s4[l] <= mul_rule(pop_data.c0, rule_at(2'(l), row0, col0))
				          + mul_rule(pop_data.c1, rule_at(2'(l), row0, col1));
				a1_s4[l] <= mul_rule(pop_data.c0, rule_at(2'(l), row1, col0))
				          + mul_rule(pop_data.c1, rule_at(2'(l), row1, col1));
				sum_s5[l] <= SUM_W'($signed({1'b0, e0_s4})) * SUM_W'(a0_s4[l])
				           + SUM_W'($signed({1'b0, e1_s4})) * SUM_W'(a1_s4[l]);
				pg_s6[l]  <= PG_W'(sum_s5[l]) * PG_W'(gain[l]);
				res_q[l]  <= ok_s6 ? pg_s6[l][RES_LSB+OUT_W-1:RES_LSB] : '0;
			end
		end
	end

endmodule

### hdl/fuzzy_pid_gain_tuner_core.sv
// Fuzzy self-tuning PID gain adjuster: one Kp/Ki/Kd adjustment item per error
// item, through a 7x7 rule base per gain. The front end (3 stages: sign and
// change, Q16.16 scaling multiply, fuzzification) feeds a 4-entry queue that
// the back end (change and error weighting, gain multiply and the output
// register) drains. One item is taken per clock cycle when the output is not
// stalled; on its way an item passes the front stages, one queue slot, the
// back stages and the output register. The configuration registers are read
// directly by the datapath and should be written only while no item is in
// flight. Depends on fpgt_pkg and on fpgt_front, fpgt_queue, fpgt_back.
module fuzzy_pid_gain_tuner_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [fpgt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fpgt_pkg::CFG_W-1:0]            cfg_data,
	// input items
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [fpgt_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // error_now, error_prev
	// result items
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [fpgt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // kp, ki, kd adjust, pad
);
	import fpgt_pkg::*;

	logic [SCALE_W-1:0]       quant_scale_q;
	logic signed [GAIN_W-1:0] gain_q [LANES];
	logic signed [OUT_W-1:0]  result [LANES];

	logic  push, pop, q_ready, q_valid;
	fuzz_t push_data, pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_scale_q <= QUANT_SCALE_RST;
			gain_q[LANE_P] <= GAIN_RST;
			gain_q[LANE_I] <= GAIN_RST;
			gain_q[LANE_D] <= GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUANT_SCALE: quant_scale_q  <= cfg_data[SCALE_W-1:0];
				REG_GAIN_P:      gain_q[LANE_P] <= $signed(cfg_data[GAIN_W-1:0]);
				REG_GAIN_I:      gain_q[LANE_I] <= $signed(cfg_data[GAIN_W-1:0]);
				REG_GAIN_D:      gain_q[LANE_D] <= $signed(cfg_data[GAIN_W-1:0]);
				default: ;
			endcase
		end
	end

	fpgt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.error_now   ($signed(s_axis_tdata[ERROR_WIDTH-1:0])),
		.error_prev  ($signed(s_axis_tdata[2*ERROR_WIDTH-1:ERROR_WIDTH])),
		.quant_scale (quant_scale_q),
		.push        (push),
		.q_ready     (q_ready),
		.push_data   (push_data)
	);

	fpgt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready),
		.q_valid   (q_valid),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	fpgt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.gain      (gain_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result    (result)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - LANES*OUT_W){1'b0}},
	                       result[LANE_D], result[LANE_I], result[LANE_P]};

endmodule

### dv/tb_fuzzy_pid_gain_tuner_core.sv
// Self-checking testbench of fuzzy_pid_gain_tuner_core: error items in, Kp/Ki/Kd adjustments out,
// each result compared with an in-bench fuzzy rule-base predictor under several register settings.
// Depends on fpgt_pkg (port widths, register indexes) and the core RTL.
`timescale 1ns / 100ps

// Rule bases of the predictor, row = error set, column = change set
localparam int KP_RULES [7][7] = '{
	'{ 3,  3,  2,  2,  1,  0,  0},
	'{ 3,  3,  2,  1,  1,  0, -1},
	'{ 2,  2,  2,  1,  0, -1, -1},
	'{ 2,  1,  1,  0, -1, -2, -2},
	'{ 1,  1,  0, -1, -1, -2, -2},
	'{ 1,  0, -1, -2, -2, -2, -3},
	'{ 0,  0, -2, -2, -2, -3, -3}
};

localparam int KI_RULES [7][7] = '{
	'{-3, -3, -2, -2, -1,  0,  0},
	'{-3, -3, -2, -1, -1,  0,  0},
	'{-3, -2, -1, -1,  0,  1,  1},
	'{-2, -1, -1,  0,  1,  2,  2},
	'{-1, -1,  0,  1,  1,  2,  3},
	'{ 0,  0,  1,  1,  2,  3,  3},
	'{ 0,  0,  1,  2,  2,  3,  3}
};

localparam int KD_RULES [7][7] = '{
	'{ 1, -1, -3, -3, -3, -2,  1},
	'{ 1, -1, -3, -2, -2, -1,  0},
	'{ 0, -1, -2, -2, -1, -1,  0},
	'{ 0, -1, -1, -1, -1, -1,  0},
	'{ 0,  0,  0,  0,  0,  0,  0},
	'{ 3, -1,  1,  1,  1,  1,  3},
	'{ 3,  2,  2,  2,  1,  1,  3}
};

localparam int FUZZ_FRAC = 12;
localparam int FUZZ_ONE  = 1 << FUZZ_FRAC;
localparam int FUZZ_TOP  = 3 * FUZZ_ONE;

// One result item as laid out in the low 54 bits of m_axis_tdata (kp lowest)
typedef struct packed {
	logic signed [17:0] kd;
	logic signed [17:0] ki;
	logic signed [17:0] kp;
} adjust_t;

// Predicts the adjustments of each accepted error item and checks the results in order
class gain_adjust_board;
	adjust_t            pending_adjusts [$];
	logic [31:0]        quant_scale;
	logic signed [15:0] gain_p;
	logic signed [15:0] gain_i;
	logic signed [15:0] gain_d;
	int                 errors;

	function new();
		quant_scale = 32'd65536;
		gain_p      = 16'sd256;
		gain_i      = 16'sd256;
		gain_d      = 16'sd256;
		errors      = 0;
	endfunction

	function void set_reg(input logic [fpgt_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		case (idx)
			fpgt_pkg::REG_QUANT_SCALE: quant_scale = val;
			fpgt_pkg::REG_GAIN_P:      gain_p = val[15:0];
			fpgt_pkg::REG_GAIN_I:      gain_i = val[15:0];
			default:                   gain_d = val[15:0];
		endcase
	endfunction

	function int pending();
		return pending_adjusts.size();
	endfunction

	// Map to Q.12 universe (floor), pick segment and slope-1 memberships
	function bit fuzzify_value(input longint x, output int seg, output longint m0,
			output longint m1);
		longint mag, prod, qm, q, u;
		int k;
		mag  = (x < 0) ? -x : x;
		prod = mag * longint'(quant_scale);
		qm   = prod >>> 16;
		// floor of a negative value: round the magnitude up
		if (x < 0 && prod[15:0] != 16'd0)
			qm = qm + 1;
		seg = 0;
		m0  = 0;
		m1  = 0;
		if (qm > FUZZ_TOP)
			return 1'b0;
		q = (x < 0) ? -qm : qm;
		u = q + FUZZ_TOP;
		k = int'(u >>> FUZZ_FRAC);
		// exactly +3 stays in the last segment
		if (k > 5)
			k = 5;
		seg = k;
		m1  = u - k * FUZZ_ONE;
		m0  = FUZZ_ONE - m1;
		return 1'b1;
	endfunction

	// Weighted sum of the four corner rules, times Q8.8 gain, floored to Q.8, saturated to 18 bits
	function logic signed [17:0] weigh_rules(input int t [7][7], input int ie, input int ic,
			input longint e0, input longint e1, input longint c0, input longint c1,
			input logic signed [15:0] gain);
		longint s, r;
		s = e0 * (c0 * t[ie][ic] + c1 * t[ie][ic+1])
			+ e1 * (c0 * t[ie+1][ic] + c1 * t[ie+1][ic+1]);
		r = (s * longint'(gain)) >>> (2 * FUZZ_FRAC);
		if (r > 131071)
			r = 131071;
		if (r < -131072)
			r = -131072;
		return r[17:0];
	endfunction

	function void note_error_item(input logic [31:0] d);
		longint now_v, chg_v, e0, e1, c0, c1;
		int ie, ic;
		bit ok_e, ok_c;
		adjust_t a;
		now_v = longint'($signed(d[15:0]));
		chg_v = now_v - longint'($signed(d[31:16]));
		ok_e  = fuzzify_value(now_v, ie, e0, e1);
		ok_c  = fuzzify_value(chg_v, ic, c0, c1);
		a = '0;
		// out of range on either axis leaves all three adjustments zero
		if (ok_e && ok_c) begin
			a.kp = weigh_rules(KP_RULES, ie, ic, e0, e1, c0, c1, gain_p);
			a.ki = weigh_rules(KI_RULES, ie, ic, e0, e1, c0, c1, gain_i);
			a.kd = weigh_rules(KD_RULES, ie, ic, e0, e1, c0, c1, gain_d);
		end
		pending_adjusts.push_back(a);
	endfunction

	function void check_adjust_item(input logic [fpgt_pkg::OUT_TDATA_W-1:0] d);
		adjust_t got, want;
		got = d[53:0];
		if (pending_adjusts.size() == 0) begin
			$error("result item with nothing expected: %h", d);
			errors++;
			return;
		end
		want = pending_adjusts.pop_front();
		if (got.kp !== want.kp) begin
			$error("kp_adjust: expected %0d, got %0d", want.kp, got.kp);
			errors++;
		end
		if (got.ki !== want.ki) begin
			$error("ki_adjust: expected %0d, got %0d", want.ki, got.ki);
			errors++;
		end
		if (got.kd !== want.kd) begin
			$error("kd_adjust: expected %0d, got %0d", want.kd, got.kd);
			errors++;
		end
	endfunction
endclass

module tb_fuzzy_pid_gain_tuner_core;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int N_DIR       = 20;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [fpgt_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [fpgt_pkg::CFG_W-1:0]          cfg_data = '0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [fpgt_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;   // error_now, error_prev
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [fpgt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;        // kp, ki, kd adjust, pad

	gain_adjust_board board;
	int cycles       = 0;
	int stall_asks   = 0;
	int stall_served = 0;
	bit steady       = 1'b0;

	int dir_now  [N_DIR] = '{0, 12288, -12288, 12289, -12289, 0, 0, 0, 0, 32767,
		-32768, 32767, -32768, 4096, -4096, 2048, -1, 1, 6000, -7000};
	int dir_prev [N_DIR] = '{0, 12288, -12288, 12289, -12289, -12288, 12288, 12289, -12289,
		-32768, 32767, 32767, -32768, 0, 4096, 1024, 0, 2, -3000, 2000};

	fuzzy_pid_gain_tuner_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Gap length: mostly none or short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] clamp16(input longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// Error value near a set center (-3..3) for the given scale
	function automatic longint boundary_point(input logic [31:0] qs);
		int k, off;
		k   = int'($urandom_range(0, 6)) - 3;
		off = int'($urandom_range(0, 2)) - 1;
		if (qs == 32'd0)
			return off;
		return longint'(k) * 268435456 / longint'(qs) + off;
	endfunction

	// Mostly in-range errors for this scale, then set centers, then raw noise
	function automatic logic [31:0] make_error_item(input logic [31:0] qs);
		longint lim, now_v, prev_v;
		int r;
		lim = (qs == 32'd0) ? 32767 : 805306368 / longint'(qs);
		if (lim > 32767)
			lim = 32767;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			now_v  = longint'($urandom_range(0, 2 * lim)) - lim;
			prev_v = now_v - (longint'($urandom_range(0, 2 * lim)) - lim);
		end else if (r < 80) begin
			now_v  = boundary_point(qs);
			prev_v = now_v - boundary_point(qs);
		end else begin
			return $urandom;
		end
		return {clamp16(prev_v), clamp16(now_v)};
	endfunction

	// Offer one item, optionally after a gap, and hold it until accepted
	task automatic send_item(input logic [31:0] d, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= d;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop offering and wait for every outstanding result plus pipeline slack
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic put_reg(input logic [fpgt_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_we    <= 1'b1;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	// Upper bits of the P and I gain writes are junk, those of D are zero; only the low 16 count
	task automatic write_tuning(input logic [31:0] qs, input logic [15:0] gp,
			input logic [15:0] gi, input logic [15:0] gd);
		logic [15:0] junk;
		junk = $urandom;
		put_reg(fpgt_pkg::REG_QUANT_SCALE, qs);
		put_reg(fpgt_pkg::REG_GAIN_P, {junk, gp});
		put_reg(fpgt_pkg::REG_GAIN_I, {~junk, gi});
		put_reg(fpgt_pkg::REG_GAIN_D, {16'h0000, gd});
		cfg_we <= 1'b0;
	endtask

	// Input and result monitors
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_error_item(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_adjust_item(m_axis_tdata);
	end

	// Receiver: random back-pressure, steady stretches, one long hold-off on request
	initial begin
		int g;
		wait (arst_n);
		forever begin
			if (stall_asks != stall_served) begin
				stall_served = stall_asks;
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!steady) begin
				g = idle_len();
				if (g > 0) begin
					m_axis_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_fuzzy_pid_gain_tuner_core: done, errors");
		$finish;
	end

	// Main sequence
	initial begin
		int ph, i, n;
		logic [31:0] qs;
		logic [15:0] gp, gi, gd;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under reset settings: center, both edges of the universe, out of range, extremes
		for (i = 0; i < N_DIR; i++)
			send_item({clamp16(dir_prev[i]), clamp16(dir_now[i])}, idle_len());
		drain_results();

		for (ph = 0; ph < 8; ph++) begin
			n = 240;
			case (ph)
				0: begin qs = 32'd65536; gp = 16'd256; gi = 16'd256; gd = 16'd256; end
				1: begin qs = 32'd12288; gp = 16'h8000; gi = 16'h7FFF; gd = -16'sd256; end
				2: begin qs = 32'd0; gp = 16'h7FFF; gi = 16'h8000; gd = 16'd1; end
				3: begin
					qs = 32'hFFFF_FFFF; gp = 16'd256; gi = 16'd256; gd = 16'd256;
					n = 100;
				end
				4: begin
					qs = $urandom_range(4096, 200000);
					gp = $urandom; gi = $urandom; gd = $urandom;
				end
				5: begin
					qs = $urandom_range(1, 70000);
					gp = $urandom; gi = $urandom; gd = $urandom;
				end
				6: begin
					qs = $urandom_range(8000, 20000);
					gp = $urandom; gi = $urandom; gd = $urandom;
				end
				default: begin qs = 32'd65536; gp = 16'hFFFF; gi = 16'h0000; gd = 16'h7FFF; end
			endcase
			write_tuning(qs, gp, gi, gd);
			steady = (ph == 2 || ph == 5);
			// long receiver hold-off while items keep coming
			if (ph == 1)
				stall_asks++;
			for (i = 0; i < n; i++) begin
				// sender pauses until everything is back
				if (ph == 4 && i % 80 == 79)
					drain_results();
				send_item(make_error_item(qs), steady ? 0 : idle_len());
			end
			drain_results();
		end
		steady = 1'b0;

		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("tb_fuzzy_pid_gain_tuner_core: done, clean");
		else
			$display("tb_fuzzy_pid_gain_tuner_core: done, errors");
		$finish;
	end

endmodule
